>>> rtl/assert_macros.svh
// Assertion macros shared by the shared region table RTL.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define SRT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRT_ASSERT_IMPL(lbl, ante, cons, msg)
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/srt_pkg.sv
// Shared types and codes of the shared region table.
// No dependencies; imported by every module of the block.
package srt_pkg;

    // Operation kinds carried in s_tuser
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_SYNC  = 2'd2;
    localparam logic [1:0] KIND_FAULT = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_GRANT_FAIL = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_NOT_OWNER  = 3'd4;

    // Access states
    localparam logic [1:0] ACC_INVALID = 2'd0;
    localparam logic [1:0] ACC_RO      = 2'd1;
    localparam logic [1:0] ACC_RW      = 2'd2;

    // Field widths
    localparam int ADDR_W   = 64;
    localparam int NODE_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;

    // Stream beat widths (whole bytes)
    localparam int IN_DATA_W  = 224;
    localparam int OUT_FLDS_W = STATUS_W + SLOT_W + ADDR_W + 1;
    localparam int OUT_DATA_W = 80;

    // Configuration register indexes
    localparam logic REG_LOCAL_NODE = 1'b0;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [NODE_W-1:0] owner;
        logic [1:0]        access;
    } entry_t;

    // Write request to the entry memory
    typedef struct packed {
        logic   en;
        entry_t data;
    } mem_wr_t;

endpackage

>>> rtl/srt_entry_mem.sv
// Entry memory of the shared region table: one write and one read port,
// read data registered. Depends on srt_pkg for the entry type.
module srt_entry_mem
    import srt_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data,
    input  mem_wr_t           wr,
    input  logic [ADDR_W-1:0] wr_addr
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/srt_apb_regs.sv
// APB configuration registers of the shared region table (local node id).
// Depends on srt_pkg for register indexes and widths.
module srt_apb_regs
    import srt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [NODE_W-1:0] local_node
);

    logic [NODE_W-1:0] local_node_reg;
    logic              wr_hit;

    // Word index sits above the byte offset
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_LOCAL_NODE);

    // Hold the local node id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_node_reg <= NODE_W'(1);
        end
        else if (wr_hit)
        begin
            local_node_reg <= pwdata[NODE_W-1:0];
        end
    end

    // Read back
    always_comb
    begin
        if (paddr[2] == REG_LOCAL_NODE)
        begin
            prdata = local_node_reg;
        end
        else
        begin
            prdata = '0;
        end
    end

    assign pready     = 1'b1;
    assign local_node = local_node_reg;

endmodule

>>> rtl/srt_scan_ctrl.sv
// Sequencer of the shared region table: slot scan over the entry memory,
// active bits, result register and write-back. Depends on srt_pkg.
`include "assert_macros.svh"
module srt_scan_ctrl
    import srt_pkg::*;
#(
    parameter int REGION_SLOTS = 64,
    parameter int PAGE_BYTES   = 4096,
    parameter int IDX_W        = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [NODE_W-1:0]     local_node,
    output logic                  mem_rd_en,
    output logic [IDX_W-1:0]      mem_rd_addr,
    input  entry_t                mem_rd_data,
    output mem_wr_t               mem_wr,
    output logic [IDX_W-1:0]      mem_wr_addr
);

    localparam int PTR_W = IDX_W + 1;
    localparam logic [PTR_W-1:0]  PTR_END   = PTR_W'(REGION_SLOTS);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(REGION_SLOTS - 1);
    localparam logic [ADDR_W-1:0] PAGE_MASK = ~(ADDR_W'(PAGE_BYTES) - ADDR_W'(1));

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t                  state_reg;
    logic [PTR_W-1:0]        ptr_reg;
    logic                    cmp_vld_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic [REGION_SLOTS-1:0] active_reg;
    logic                    m_tvalid_reg;

    // Request and captured entry (payload, no reset)
    logic [1:0]              kind_reg;
    logic [ADDR_W-1:0]       base_reg;
    logic [ADDR_W-1:0]       size_reg;
    logic [ADDR_W-1:0]       query_reg;
    logic [NODE_W-1:0]       claimed_reg;
    entry_t                  ent_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;

    logic                    accept;
    logic                    active_sel;
    logic [ADDR_W-1:0]       offset;
    logic                    contains;
    logic                    scan_hit;
    logic                    scan_stop;
    logic                    out_free;
    logic                    commit;

    logic [STATUS_W-1:0]     status_next;
    logic [SLOT_W-1:0]       slot_next;
    logic [ADDR_W-1:0]       page_next;
    logic                    sent_next;
    logic                    alloc_next;
    logic                    clear_next;
    mem_wr_t                 wr_next;

    assign accept   = s_tvalid && (state_reg == S_IDLE);
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == S_RESULT) && out_free;

    // Issue one slot read a cycle while the scan pointer is in range
    assign mem_rd_en   = (state_reg == S_SCAN) && (ptr_reg < PTR_END);
    assign mem_rd_addr = ptr_reg[IDX_W-1:0];

    // Compare the slot whose data has just come back
    assign active_sel = active_reg[cmp_idx_reg];
    assign offset     = query_reg - mem_rd_data.base;
    assign contains   = active_sel && (query_reg >= mem_rd_data.base)
                        && (offset < mem_rd_data.size);

    always_comb
    begin
        unique case (kind_reg)
            KIND_ALLOC: scan_hit = !active_sel;
            KIND_FREE:  scan_hit = active_sel && (mem_rd_data.base == query_reg);
            KIND_SYNC:  scan_hit = contains;
            KIND_FAULT: scan_hit = contains;
        endcase
    end

    assign scan_stop = cmp_vld_reg && (scan_hit || (cmp_idx_reg == IDX_LAST));

    // Work out the result and the table update from the scan outcome
    always_comb
    begin
        status_next  = ST_OK;
        slot_next    = SLOT_W'(hit_idx_reg);
        page_next    = '0;
        sent_next    = 1'b0;
        alloc_next   = 1'b0;
        clear_next   = 1'b0;
        wr_next.en   = 1'b0;
        wr_next.data = ent_reg;
        if (!found_reg)
        begin
            slot_next = '0;
            if (kind_reg == KIND_ALLOC)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_NOT_FOUND;
            end
        end
        else
        begin
            unique case (kind_reg)
                KIND_ALLOC:
                begin
                    if (base_reg == '0)
                    begin
                        status_next = ST_GRANT_FAIL;
                        slot_next   = '0;
                    end
                    else
                    begin
                        alloc_next          = 1'b1;
                        wr_next.en          = 1'b1;
                        wr_next.data.base   = base_reg;
                        wr_next.data.size   = size_reg;
                        wr_next.data.owner  = local_node;
                        wr_next.data.access = ACC_RW;
                    end
                end
                KIND_FREE:
                begin
                    clear_next = 1'b1;
                end
                KIND_SYNC:
                begin
                    page_next = query_reg & PAGE_MASK;
                    if (claimed_reg != local_node)
                    begin
                        sent_next           = 1'b1;
                        wr_next.en          = 1'b1;
                        wr_next.data.access = ACC_RO;
                    end
                end
                KIND_FAULT:
                begin
                    if (ent_reg.owner != local_node)
                    begin
                        status_next = ST_NOT_OWNER;
                    end
                    else
                    begin
                        page_next = query_reg & PAGE_MASK;
                    end
                end
            endcase
        end
    end

    // Write back only when the result is committed
    assign mem_wr.en   = wr_next.en && commit;
    assign mem_wr.data = wr_next.data;
    assign mem_wr_addr = hit_idx_reg;

    // Sequencer, active bits and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ptr_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            found_reg    <= 1'b0;
            hit_idx_reg  <= '0;
            active_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // Drop the beat once taken, unless a new one replaces it
            if (m_tvalid_reg && m_tready && !commit)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ptr_reg     <= '0;
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    cmp_vld_reg <= mem_rd_en && !scan_stop;
                    cmp_idx_reg <= mem_rd_addr;
                    if (mem_rd_en)
                    begin
                        ptr_reg <= ptr_reg + PTR_W'(1);
                    end
                    if (scan_stop)
                    begin
                        found_reg   <= scan_hit;
                        hit_idx_reg <= cmp_idx_reg;
                        state_reg   <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        if (alloc_next)
                        begin
                            active_reg[hit_idx_reg] <= 1'b1;
                        end
                        if (clear_next)
                        begin
                            active_reg[hit_idx_reg] <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Latch the request, the matched entry and the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= s_tuser;
            base_reg    <= s_tdata[63:0];
            size_reg    <= s_tdata[127:64];
            query_reg   <= s_tdata[191:128];
            claimed_reg <= s_tdata[223:192];
        end
        if ((state_reg == S_SCAN) && scan_stop)
        begin
            ent_reg <= mem_rd_data;
        end
        if (commit)
        begin
            m_tdata_reg <= OUT_DATA_W'({sent_next, page_next, slot_next, status_next});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The memory is only written while a result is committed
    `SRT_ASSERT_IMPL(a_wr_in_result, mem_wr.en, state_reg == S_RESULT, "write outside result")
    // An allocation never lands on a slot that is in use
    `SRT_ASSERT_IMPL(a_alloc_free_slot, commit && alloc_next, !active_reg[hit_idx_reg], "alloc on active slot")
    // A new result beat only follows a committed result
    `SRT_ASSERT_IMPL(a_beat_from_result, $rose(m_tvalid_reg), $past(state_reg == S_RESULT), "stray result beat")
    // An accepted beat starts a scan from slot zero
    `SRT_ASSERT_NEXT(a_accept_scan, accept, (state_reg == S_SCAN) && (ptr_reg == '0), "scan not started")

endmodule

>>> rtl/shared_region_table_core.sv
// Top level of the shared region table: APB registers, entry memory, sequencer.
// Depends on srt_pkg, srt_apb_regs, srt_entry_mem and srt_scan_ctrl.
//
// Shared region table. One request beat (allocate, free, sync page or remote
// fault) is taken at a time and gives exactly one result beat. Each request
// scans the slots from index 0 upward through the entry memory (one read and
// one write port, registered read data), one slot per cycle, and stops at the
// first match, or at the last slot when no slot matches or the table is full.
// Each slot read returns registered data that is then compared; on a stop the
// sequencer enters its result state and loads the result register. A new
// request is taken the cycle after the previous result has been loaded, even
// while that result beat still waits on m_tready. Active bits are cleared at
// reset at once; no clearing pass is needed. local_node sits at byte
// address 0 of the APB port and resets to 1; write it only while no
// request is in flight.
module shared_region_table_core
    import srt_pkg::*;
#(
    parameter int REGION_SLOTS = 64,
    parameter int PAGE_BYTES   = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: region_base[63:0], region_size[127:64], query_addr[191:128],
    // claimed_owner[223:192]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: kind[1:0]
    input  logic [1:0]            s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: status[2:0], slot_index[8:3], page_base[72:9], request_sent[73],
    // zero fill[79:74]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(REGION_SLOTS);

    logic [NODE_W-1:0] local_node;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    entry_t            mem_rd_data;
    mem_wr_t           mem_wr;
    logic [IDX_W-1:0]  mem_wr_addr;

    srt_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .local_node (local_node)
    );

    srt_entry_mem #(
        .DEPTH  (REGION_SLOTS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr      (mem_wr),
        .wr_addr (mem_wr_addr)
    );

    srt_scan_ctrl #(
        .REGION_SLOTS (REGION_SLOTS),
        .PAGE_BYTES   (PAGE_BYTES),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .local_node  (local_node),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr      (mem_wr),
        .mem_wr_addr (mem_wr_addr)
    );

endmodule
